[rtl/core/elms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elms_pkg
// Shared types, register indexes and reset values for the limp mode
// supervisor.
// ----------------------------------------------------------------------------
package elms_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int TIME_BITS_MAX = 64;
  localparam int NOW_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int RPM_W         = 16;
  localparam int TEMP_W        = 9;
  localparam int VOLT_W        = 8;
  localparam int MS_W          = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RPM_CUTOFF    = 3'd0,
    REG_RPM_MAXIMUM   = 3'd1,
    REG_OVERHEAT_TEMP = 3'd2,
    REG_BATT_LOW      = 3'd3,
    REG_BATT_HIGH     = 3'd4,
    REG_MIN_LIMP_MS   = 3'd5,
    REG_RECOV_HOLD_MS = 3'd6
  } cfg_idx_e;

  localparam logic [RPM_W-1:0]         RST_RPM_CUTOFF    = 16'd7000;
  localparam logic [RPM_W-1:0]         RST_RPM_MAXIMUM   = 16'd8000;
  localparam logic signed [TEMP_W-1:0] RST_OVERHEAT_TEMP = 9'sd105;
  localparam logic [VOLT_W-1:0]        RST_BATT_LOW      = 8'd90;
  localparam logic [VOLT_W-1:0]        RST_BATT_HIGH     = 8'd160;
  localparam logic [MS_W-1:0]          RST_MIN_LIMP_MS   = 16'd5000;
  localparam logic [MS_W-1:0]          RST_RECOV_HOLD_MS = 16'd2000;

  typedef struct packed {
    logic [RPM_W-1:0]         rpm_cutoff;
    logic [RPM_W-1:0]         rpm_maximum;
    logic signed [TEMP_W-1:0] overheat_temp;
    logic [VOLT_W-1:0]        battery_low_limit;
    logic [VOLT_W-1:0]        battery_high_limit;
    logic [MS_W-1:0]          min_limp_ms;
    logic [MS_W-1:0]          recovery_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic rev_limit;
    logic overheat;
    logic battery;
  } fault_t;

  typedef struct packed {
    logic limp_active;
    logic limp_entered;
    logic recovery_pending;
    logic limp_recovered;
  } limp_status_t;

endpackage

[rtl/core/engine_limp_mode_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// engine_limp_mode_supervisor
// Limp mode entry and timed recovery supervisor, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one timestamped item: an
//   optional rpm/coolant/battery sample, a conditions-safe flag and a
//   recovery request. Output channel (out_valid/out_ready) returns one
//   result transaction per input transaction, in order.
//   Config channel (cfg_valid/cfg_ready) writes one register per
//   transaction; cfg_ready is always high, unknown indexes are dropped.
//   Write config only while no item is in flight.
// Timing:
//   An accepted item sits in the input register while the limit checks
//   and the limp state update run, then lands in the result register.
//   Throughput is one item per clock while out_ready is high; the limp
//   state registers are the only feedback path.
// Reset:
//   rst clears both pipeline valids, the limp state and loads the default
//   register values.
// Backpressure:
//   When out_ready is low the result register holds, the input register
//   keeps its item, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module engine_limp_mode_supervisor
  import elms_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // input transactions
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [NOW_W-1:0]         now_ms,
  input  logic                     sample_valid,
  input  logic [RPM_W-1:0]         rpm,
  input  logic signed [TEMP_W-1:0] coolant_temp,
  input  logic [VOLT_W-1:0]        battery_voltage,
  input  logic                     conditions_safe,
  input  logic                     recover_request,
  // result transactions
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     limp_active,
  output logic                     over_rev_fault,
  output logic                     overheat_fault,
  output logic                     battery_fault,
  output logic                     limp_entered,
  output logic                     recovery_pending,
  output logic                     limp_recovered,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t         cfg;
  fault_t       fault;
  limp_status_t status;

  // input register
  logic                     s1_valid;
  logic [NOW_W-1:0]         s1_now_ms;
  logic                     s1_sample_valid;
  logic [RPM_W-1:0]         s1_rpm;
  logic signed [TEMP_W-1:0] s1_coolant_temp;
  logic [VOLT_W-1:0]        s1_battery_voltage;
  logic                     s1_conditions_safe;
  logic                     s1_recover_request;

  // result register
  logic         res_valid;
  fault_t       res_fault;
  limp_status_t res_status;

  logic res_load;
  logic s1_adv;
  logic in_fire;

  assign cfg_ready = 1'b1;

  // Result register frees up when empty or when its transaction is taken.
  assign res_load = !res_valid || out_ready;
  assign s1_adv   = s1_valid && res_load;
  assign in_ready = !s1_valid || res_load;
  assign in_fire  = in_valid && in_ready;

  elms_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  elms_fault_check u_fault_check (
    .cfg             (cfg),
    .sample_valid    (s1_sample_valid),
    .rpm             (s1_rpm),
    .coolant_temp    (s1_coolant_temp),
    .battery_voltage (s1_battery_voltage),
    .fault           (fault)
  );

  // State advances exactly when the item leaves the input register.
  elms_limp_state #(
    .TIME_BITS (TIME_BITS)
  ) u_limp_state (
    .clk             (clk),
    .rst             (rst),
    .step            (s1_adv),
    .cfg             (cfg),
    .now_ms          (s1_now_ms),
    .fault_any       (fault.rev_limit || fault.overheat || fault.battery),
    .conditions_safe (s1_conditions_safe),
    .recover_request (s1_recover_request),
    .status          (status)
  );

  // Input register: valid bit is control, payload loads on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_ms          <= now_ms;
      s1_sample_valid    <= sample_valid;
      s1_rpm             <= rpm;
      s1_coolant_temp    <= coolant_temp;
      s1_battery_voltage <= battery_voltage;
      s1_conditions_safe <= conditions_safe;
      s1_recover_request <= recover_request;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_fault  <= fault;
      res_status <= status;
    end
  end

  assign out_valid        = res_valid;
  assign limp_active      = res_status.limp_active;
  assign over_rev_fault   = res_fault.rev_limit;
  assign overheat_fault   = res_fault.overheat;
  assign battery_fault    = res_fault.battery;
  assign limp_entered     = res_status.limp_entered;
  assign recovery_pending = res_status.recovery_pending;
  assign limp_recovered   = res_status.limp_recovered;

  // Entry and recovery never come from the same item.
  a_enter_xor_recover: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(limp_entered && limp_recovered))
    else $error("limp entered and recovered in one result");

  // A recovered result leaves limp and monitoring both clear.
  a_recover_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && limp_recovered) |-> (!limp_active && !recovery_pending))
    else $error("recovery left limp or monitoring set");

  // Monitoring only runs inside limp mode after a processed item.
  a_pending_in_limp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && recovery_pending) |-> limp_active)
    else $error("recovery pending outside limp mode");

  // An entered result must report limp active and a fault behind it.
  a_entry_has_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && limp_entered) |->
      (limp_active && (over_rev_fault || overheat_fault || battery_fault)))
    else $error("limp entered without fault");

endmodule

[rtl/core/elms_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elms_cfg_regs
// Configuration register file; out-of-range indexes are dropped.
// ----------------------------------------------------------------------------
module elms_cfg_regs
  import elms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_q;
  cfg_t cfg_q_next;

  always_comb begin
    cfg_q_next = cfg_q;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RPM_CUTOFF:    cfg_q_next.rpm_cutoff         = cfg_data[RPM_W-1:0];
        REG_RPM_MAXIMUM:   cfg_q_next.rpm_maximum        = cfg_data[RPM_W-1:0];
        REG_OVERHEAT_TEMP: cfg_q_next.overheat_temp      = cfg_data[TEMP_W-1:0];
        REG_BATT_LOW:      cfg_q_next.battery_low_limit  = cfg_data[VOLT_W-1:0];
        REG_BATT_HIGH:     cfg_q_next.battery_high_limit = cfg_data[VOLT_W-1:0];
        REG_MIN_LIMP_MS:   cfg_q_next.min_limp_ms        = cfg_data[MS_W-1:0];
        REG_RECOV_HOLD_MS: cfg_q_next.recovery_hold_ms   = cfg_data[MS_W-1:0];
        default:           cfg_q_next = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.rpm_cutoff         <= RST_RPM_CUTOFF;
      cfg_q.rpm_maximum        <= RST_RPM_MAXIMUM;
      cfg_q.overheat_temp      <= RST_OVERHEAT_TEMP;
      cfg_q.battery_low_limit  <= RST_BATT_LOW;
      cfg_q.battery_high_limit <= RST_BATT_HIGH;
      cfg_q.min_limp_ms        <= RST_MIN_LIMP_MS;
      cfg_q.recovery_hold_ms   <= RST_RECOV_HOLD_MS;
    end else begin
      cfg_q <= cfg_q_next;
    end
  end

  assign cfg = cfg_q;

endmodule

[rtl/core/elms_fault_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elms_fault_check
// Sample limit checks: over-rev, overheat and battery window.
// ----------------------------------------------------------------------------
module elms_fault_check
  import elms_pkg::*;
(
  input  cfg_t                     cfg,
  input  logic                     sample_valid,
  input  logic [RPM_W-1:0]         rpm,
  input  logic signed [TEMP_W-1:0] coolant_temp,
  input  logic [VOLT_W-1:0]        battery_voltage,
  output fault_t                   fault
);

  always_comb begin
    fault.rev_limit = sample_valid &&
                      ((rpm >= cfg.rpm_cutoff) || (rpm > cfg.rpm_maximum));
    fault.overheat  = sample_valid && (coolant_temp > cfg.overheat_temp);
    fault.battery   = sample_valid &&
                      ((battery_voltage < cfg.battery_low_limit) ||
                       (battery_voltage > cfg.battery_high_limit));
  end

endmodule

[rtl/core/elms_limp_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elms_limp_state
// Limp and recovery monitoring state, updated once per processed item.
// ----------------------------------------------------------------------------
module elms_limp_state
  import elms_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cfg_t             cfg,
  input  logic [NOW_W-1:0] now_ms,
  input  logic             fault_any,
  input  logic             conditions_safe,
  input  logic             recover_request,
  output limp_status_t     status
);

  logic [TIME_BITS_MAX-1:0] now_wide;
  logic [TIME_BITS_MAX-1:0] min_wide;
  logic [TIME_BITS_MAX-1:0] hold_wide;
  logic [TIME_BITS-1:0]     now_t;
  logic [TIME_BITS-1:0]     min_t;
  logic [TIME_BITS-1:0]     hold_t;

  logic                 limp_flag, limp_flag_next;
  logic [TIME_BITS-1:0] entry_time, entry_time_next;
  logic                 monitoring_flag, monitoring_flag_next;
  logic [TIME_BITS-1:0] monitor_start_time, monitor_start_time_next;

  logic                 entered;
  logic                 recovered;
  logic                 mon_kept;
  logic [TIME_BITS-1:0] mst_kept;
  logic [TIME_BITS-1:0] limp_age;
  logic [TIME_BITS-1:0] mon_age;

  // Widen, then cut to the time width so any TIME_BITS in range works.
  assign now_wide  = TIME_BITS_MAX'(now_ms);
  assign min_wide  = TIME_BITS_MAX'(cfg.min_limp_ms);
  assign hold_wide = TIME_BITS_MAX'(cfg.recovery_hold_ms);
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign min_t     = min_wide[TIME_BITS-1:0];
  assign hold_t    = hold_wide[TIME_BITS-1:0];

  always_comb begin
    // unsafe conditions drop monitoring first
    mon_kept = conditions_safe && monitoring_flag;
    mst_kept = conditions_safe ? monitor_start_time : '0;

    entered         = fault_any && !limp_flag;
    limp_flag_next  = limp_flag || entered;
    entry_time_next = entered ? now_t : entry_time;

    monitoring_flag_next    = mon_kept;
    monitor_start_time_next = mst_kept;
    recovered               = 1'b0;

    limp_age = now_t - entry_time_next;
    mon_age  = now_t - mst_kept;

    if (recover_request && limp_flag_next && (limp_age >= min_t)) begin
      if (!mon_kept) begin
        monitoring_flag_next    = 1'b1;
        monitor_start_time_next = now_t;
      end else if (mon_age >= hold_t) begin
        limp_flag_next          = 1'b0;
        entry_time_next         = '0;
        monitoring_flag_next    = 1'b0;
        monitor_start_time_next = '0;
        recovered               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limp_flag          <= 1'b0;
      entry_time         <= '0;
      monitoring_flag    <= 1'b0;
      monitor_start_time <= '0;
    end else if (step) begin
      limp_flag          <= limp_flag_next;
      entry_time         <= entry_time_next;
      monitoring_flag    <= monitoring_flag_next;
      monitor_start_time <= monitor_start_time_next;
    end
  end

  always_comb begin
    status.limp_active      = limp_flag_next;
    status.limp_entered     = entered;
    status.recovery_pending = monitoring_flag_next;
    status.limp_recovered   = recovered;
  end

endmodule
